@@ rtl/oaids_pkg.sv @@
// ----------------------------------------------------------------------------
// oaids_pkg: shared types and constants
// Field widths, operation and status codes for the ordered table block.
// ----------------------------------------------------------------------------
`default_nettype none

package oaids_pkg;

  localparam int MODE_W  = 2;
  localparam int POS_W   = 6;
  localparam int VALUE_W = 32;
  localparam int STAT_W  = 3;
  localparam int FPOS_W  = 6;
  localparam int ECNT_W  = 6;

  typedef enum logic [MODE_W-1:0] {
    MODE_INSERT   = 2'd0,
    MODE_DELETE   = 2'd1,
    MODE_SEARCH   = 2'd2,
    MODE_TRAVERSE = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_BADPOS   = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

endpackage

`default_nettype wire

@@ rtl/oaids_if.sv @@
// ----------------------------------------------------------------------------
// oaids channel interfaces
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface oaids_req_if;
  import oaids_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic [POS_W-1:0]           position;
  logic signed [VALUE_W-1:0]  item_value;

  modport source (output valid, output mode, output position, output item_value,
                  input ready);
  modport sink   (input valid, input mode, input position, input item_value,
                  output ready);
endinterface

interface oaids_rsp_if;
  import oaids_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [STAT_W-1:0]          status;
  logic [FPOS_W-1:0]          found_position;
  logic signed [VALUE_W-1:0]  element;
  logic [ECNT_W-1:0]          entry_count;
  logic                       last;

  modport source (output valid, output status, output found_position,
                  output element, output entry_count, output last, input ready);
  modport sink   (input valid, input status, input found_position,
                  input element, input entry_count, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/oaids_ram.sv @@
// ----------------------------------------------------------------------------
// oaids_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module oaids_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/ordered_array_insert_delete_search.sv @@
// Insert: shifts the entries from the insert position up by one, then writes the new value;
//   delete: shifts the entries above the removed one down; one RAM move per cycle, then the result.
// Search: scans up to count entries from the first, one compare per cycle on the RAM read port.
// Traverse: each entry is read (S_TRD), then loaded into the output register once it is free (S_TWT); count results.
// One item at a time; req.ready is high only while the sequencer idles.
// Reset clears the entry count and control; table words hold garbage until written.
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_search: ordered table with insert/delete/search
// Sequencer walks a single RAM to shift, scan and stream table entries.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_insert_delete_search #(
  parameter int DEPTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  oaids_req_if.sink  req,
  oaids_rsp_if.source rsp
);
  import oaids_pkg::*;

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int AW   = $clog2(DEPTH);
  localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INS  = 7'b0000010,
    S_DEL  = 7'b0000100,
    S_SRCH = 7'b0001000,
    S_TRD  = 7'b0010000,
    S_TWT  = 7'b0100000,
    S_RESP = 7'b1000000
  } state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     tgt;
  logic [AW-1:0]     pend_w;
  logic              pend_v;
  logic [VALUE_W-1:0] key;
  status_t           res_status;
  logic [FPOS_W-1:0] res_fpos;

  logic              rsp_valid;
  status_t           o_status;
  logic [FPOS_W-1:0] o_fpos;
  logic [VALUE_W-1:0] o_elem;
  logic [ECNT_W-1:0] o_count;
  logic              o_last;

  logic               we;
  logic [AW-1:0]      waddr;
  logic [VALUE_W-1:0] wdata;
  logic [AW-1:0]      raddr;
  logic [VALUE_W-1:0] rdata;

  logic [CW-1:0]   idx_dec;
  logic [CW-1:0]   idx_inc;
  logic [CW-1:0]   hit_pos;
  logic            issue;
  logic            match;
  logic            step_done;
  logic            out_free;
  logic            load_out;
  logic            accept;
  logic [CMPW-1:0] pos_x;
  logic [CMPW-1:0] cnt_x;
  logic [CMPW-1:0] pos_m1;

  oaids_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == S_IDLE);
  assign out_free = !rsp_valid || rsp.ready;
  assign pos_x    = CMPW'(req.position);
  assign cnt_x    = CMPW'(count);
  assign pos_m1   = pos_x - CMPW'(1);
  assign idx_dec  = idx - CW'(1);
  assign idx_inc  = idx + CW'(1);
  assign hit_pos  = CW'(pend_w) + CW'(1);
  assign match    = pend_v && (rdata == key);

  // Read/write port steering; a pending read returns the data to move in the next cycle.
  always_comb begin
    issue = 1'b0;
    raddr = idx[AW-1:0];
    we    = 1'b0;
    waddr = pend_w;
    wdata = rdata;
    case (state)
      S_INS: begin
        issue = (idx > tgt);
        raddr = idx_dec[AW-1:0];
        if (pend_v) begin
          we = 1'b1;
        end else if (!issue) begin
          we    = 1'b1;
          waddr = tgt[AW-1:0];
          wdata = key;
        end
      end
      S_DEL: begin
        issue = (idx_inc < count);
        raddr = idx_inc[AW-1:0];
        we    = pend_v;
      end
      S_SRCH: begin
        issue = (idx < count) && !match;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  assign step_done = !issue && !pend_v;
  assign load_out  = ((state == S_RESP) || (state == S_TWT)) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      count  <= '0;
      pend_v <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend_v   <= 1'b0;
            key      <= req.item_value;
            res_fpos <= '0;
            case (mode_t'(req.mode))
              MODE_INSERT: begin
                if (cnt_x >= CMPW'(DEPTH)) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else if (pos_x == '0 || pos_x > cnt_x + CMPW'(1)) begin
                  res_status <= ST_BADPOS;
                  state      <= S_RESP;
                end else begin
                  idx   <= count;
                  tgt   <= pos_m1[CW-1:0];
                  state <= S_INS;
                end
              end
              MODE_DELETE: begin
                if (pos_x == '0 || pos_x > cnt_x) begin
                  res_status <= ST_BADPOS;
                  state      <= S_RESP;
                end else begin
                  idx   <= pos_m1[CW-1:0];
                  state <= S_DEL;
                end
              end
              MODE_SEARCH: begin
                idx   <= '0;
                state <= S_SRCH;
              end
              MODE_TRAVERSE: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_RESP;
                end else begin
                  idx   <= '0;
                  state <= S_TRD;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_INS: begin
          pend_v <= issue;
          pend_w <= idx[AW-1:0];
          if (issue) begin
            idx <= idx_dec;
          end
          if (step_done) begin
            count      <= count + CW'(1);
            res_status <= ST_OK;
            state      <= S_RESP;
          end
        end
        S_DEL: begin
          pend_v <= issue;
          pend_w <= idx[AW-1:0];
          if (issue) begin
            idx <= idx_inc;
          end
          if (step_done) begin
            count      <= count - CW'(1);
            res_status <= ST_OK;
            state      <= S_RESP;
          end
        end
        S_SRCH: begin
          pend_v <= issue;
          pend_w <= idx[AW-1:0];
          if (issue) begin
            idx <= idx_inc;
          end
          if (match) begin
            res_status <= ST_OK;
            res_fpos   <= FPOS_W'(hit_pos);
            state      <= S_RESP;
          end else if (step_done) begin
            res_status <= ST_NOTFOUND;
            state      <= S_RESP;
          end
        end
        S_TRD: begin
          state <= S_TWT;
        end
        S_TWT: begin
          if (out_free) begin
            idx <= idx_inc;
            if (idx_inc == count) begin
              state <= S_IDLE;
            end else begin
              state <= S_TRD;
            end
          end
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_count <= ECNT_W'(count);
      if (state == S_TWT) begin
        o_status <= ST_OK;
        o_fpos   <= '0;
        o_elem   <= rdata;
        o_last   <= (idx_inc == count);
      end else begin
        o_status <= res_status;
        o_fpos   <= res_fpos;
        o_elem   <= '0;
        o_last   <= 1'b1;
      end
    end
  end

  assign rsp.valid          = rsp_valid;
  assign rsp.status         = o_status;
  assign rsp.found_position = o_fpos;
  assign rsp.element        = o_elem;
  assign rsp.entry_count    = o_count;
  assign rsp.last           = o_last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above table depth");

  a_we_in_shift: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_INS || state == S_DEL))
    else $error("table write outside insert/delete");

  a_ins_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_INS && step_done) |=> count == CW'($past(count) + CW'(1)))
    else $error("insert did not bump entry count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (!rsp_valid || rsp.ready))
    else $error("result register loaded while holding a pending result");

endmodule

`default_nettype wire

@@ bench/oaids_table_checker.sv @@
// ----------------------------------------------------------------------------
// oaids_table_checker: result predictor and scoreboard
// Watches the request and result channels of the ordered table block, keeps
// its own copy of the table, and compares every result transaction field by
// field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module oaids_table_checker #(
  parameter int DEPTH = 32
) (
  input  logic clk,
  input  logic rst,
  oaids_req_if req,
  oaids_rsp_if rsp,
  output int   mismatch_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import oaids_pkg::*;

  typedef struct {
    status_t                    status;
    logic [FPOS_W-1:0]          found_position;
    logic signed [VALUE_W-1:0]  element;
    logic [ECNT_W-1:0]          entry_count;
    logic                       last;
  } table_result_t;

  table_result_t              pending_results[$];
  logic signed [VALUE_W-1:0]  table_words[$];

  task automatic push_result(status_t st, int fpos, logic signed [VALUE_W-1:0] elem,
                             bit is_last);
    table_result_t r;
    r.status         = st;
    r.found_position = FPOS_W'(fpos);
    r.element        = elem;
    r.entry_count    = ECNT_W'(table_words.size());
    r.last           = is_last;
    pending_results.push_back(r);
  endtask

  task automatic predict_table_op(mode_t m, logic [POS_W-1:0] p,
                                  logic signed [VALUE_W-1:0] v);
    int n;
    int hit;
    int i;
    n   = table_words.size();
    hit = 0;
    case (m)
      MODE_INSERT: begin
        if (n >= DEPTH) begin
          push_result(ST_FULL, 0, '0, 1'b1);
        end else if (p < 1 || p > n + 1) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          table_words.insert(p - 1, v);
          push_result(ST_OK, 0, '0, 1'b1);
        end
      end
      MODE_DELETE: begin
        if (p < 1 || p > n) begin
          push_result(ST_BADPOS, 0, '0, 1'b1);
        end else begin
          table_words.delete(p - 1);
          push_result(ST_OK, 0, '0, 1'b1);
        end
      end
      MODE_SEARCH: begin
        for (i = 0; i < n && hit == 0; i++)
          if (table_words[i] === v) hit = i + 1;
        if (hit != 0) push_result(ST_OK, hit, '0, 1'b1);
        else push_result(ST_NOTFOUND, 0, '0, 1'b1);
      end
      default: begin
        if (n == 0) begin
          push_result(ST_EMPTY, 0, '0, 1'b1);
        end else begin
          for (i = 0; i < n; i++)
            push_result(ST_OK, 0, table_words[i], i == n - 1);
        end
      end
    endcase
  endtask

  task automatic log_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic check_result();
    table_result_t e;
    if (pending_results.size() == 0) begin
      log_mismatch($sformatf("unexpected result status=%0d fpos=%0d elem=%0d cnt=%0d last=%0b",
                             rsp.status, rsp.found_position, rsp.element,
                             rsp.entry_count, rsp.last));
    end else begin
      e = pending_results.pop_front();
      if (rsp.status !== e.status || rsp.found_position !== e.found_position ||
          rsp.element !== e.element || rsp.entry_count !== e.entry_count ||
          rsp.last !== e.last)
        log_mismatch($sformatf({"exp status=%0d fpos=%0d elem=%0d cnt=%0d last=%0b",
                                " got status=%0d fpos=%0d elem=%0d cnt=%0d last=%0b"},
                               e.status, e.found_position, e.element, e.entry_count,
                               e.last, rsp.status, rsp.found_position, rsp.element,
                               rsp.entry_count, rsp.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pending_results.delete();
      table_words.delete();
      mismatch_count = 0;
    end else begin
      // results leaving at this edge can only belong to earlier requests
      if (rsp.valid && rsp.ready) check_result();
      if (req.valid && req.ready)
        predict_table_op(mode_t'(req.mode), req.position, req.item_value);
    end
    outstanding = pending_results.size();
  end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: ordered table insert/delete/search testbench
// Directed corner items, then random phases that fill, drain and mix the
// table under bursty request traffic and a stalling result consumer.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import oaids_pkg::*;

  localparam int TABLE_DEPTH  = 32;
  localparam int RANDOM_ITEMS = 240;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_POS      = 33;

  typedef enum int {PH_GROW, PH_SHRINK, PH_MIX} phase_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  oaids_req_if req ();
  oaids_rsp_if rsp ();

  int mismatches;
  int outstanding;

  int burst_left  = 0;
  bit tx_free     = 1'b0;
  bit rx_free     = 1'b0;
  bit rx_hold_req = 1'b0;
  int held_count  = 0;
  logic signed [VALUE_W-1:0] seen_values[$];

  ordered_array_insert_delete_search #(.DEPTH(TABLE_DEPTH)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  oaids_table_checker #(.DEPTH(TABLE_DEPTH)) u_checker (
    .clk            (clk),
    .rst            (rst),
    .req            (req),
    .rsp            (rsp),
    .mismatch_count (mismatches),
    .outstanding    (outstanding)
  );

  always #1 clk = ~clk;

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // result consumer: random ready runs, or one long hold-off on request
  initial begin
    int run;
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run = $urandom_range(1, 16);
        rsp.ready <= rx_free || ($urandom_range(0, 2) != 0);
        repeat (run) @(posedge clk);
      end
    end
  end

  task automatic send_item(mode_t m, logic [POS_W-1:0] p, logic signed [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = (tx_free || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        req.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    req.valid      <= 1'b1;
    req.mode       <= m;
    req.position   <= p;
    req.item_value <= v;
    do @(posedge clk); while (!req.ready);
    burst_left--;
  endtask

  // sends one transaction and tracks the fill level for stimulus shaping
  task automatic issue(mode_t m, logic [POS_W-1:0] p, logic signed [VALUE_W-1:0] v);
    send_item(m, p, v);
    if (m == MODE_INSERT && held_count < TABLE_DEPTH && p >= 1 && p <= held_count + 1) begin
      held_count++;
      seen_values.push_back(v);
      if (seen_values.size() > 24) void'(seen_values.pop_front());
    end else if (m == MODE_DELETE && p >= 1 && p <= held_count) begin
      held_count--;
    end
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sd0;
          3: return -32'sd1;
          default: return 32'sd1;
        endcase
      end
      1, 2: begin
        if (seen_values.size() > 0) return seen_values[$urandom_range(0, seen_values.size() - 1)];
        return $urandom;
      end
      default: return $urandom;
    endcase
  endfunction

  initial begin
    phase_kind_t kind;
    int          sent;
    int          phase;
    int          len;
    int          k;
    int          r;
    int          ins_pct;
    int          del_pct;
    int          lo;
    bit          well_formed;
    mode_t       m;
    logic [POS_W-1:0] p;

    req.valid      <= 1'b0;
    req.mode       <= MODE_INSERT;
    req.position   <= '0;
    req.item_value <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: empty table, bounds, extremes, duplicates, ends
    issue(MODE_TRAVERSE, 1, 0);
    issue(MODE_SEARCH, 1, 0);
    issue(MODE_DELETE, 1, 0);
    issue(MODE_INSERT, 2, 5);
    issue(MODE_INSERT, 1, 32'sh8000_0000);
    issue(MODE_INSERT, 2, 32'sh7FFF_FFFF);
    issue(MODE_INSERT, 1, 0);
    issue(MODE_INSERT, 4, -1);
    issue(MODE_INSERT, 33, 7);
    issue(MODE_INSERT, 6, 7);
    issue(MODE_TRAVERSE, 63, 0);
    issue(MODE_SEARCH, 0, 32'sh7FFF_FFFF);
    issue(MODE_SEARCH, 1, 32'sh8000_0000);
    issue(MODE_SEARCH, 1, 12345);
    issue(MODE_INSERT, 3, -1);
    issue(MODE_SEARCH, 1, -1);
    issue(MODE_DELETE, 6, 0);
    issue(MODE_DELETE, 5, 0);
    issue(MODE_DELETE, 1, 0);
    issue(MODE_DELETE, 33, 0);
    issue(MODE_TRAVERSE, 1, -1);
    wait_drained();

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      kind    = (phase == 0) ? PH_GROW : phase_kind_t'($urandom_range(0, 2));
      len     = $urandom_range(25, 45);
      tx_free = ($urandom_range(0, 3) == 0);
      rx_free = ($urandom_range(0, 3) == 0);
      ins_pct = (kind == PH_GROW) ? 65 : (kind == PH_SHRINK) ? 15 : 35;
      del_pct = (kind == PH_GROW) ? 10 : (kind == PH_SHRINK) ? 55 : 30;
      // long consumer hold-off while requests keep coming
      if (phase == 2) rx_hold_req = 1'b1;
      for (k = 0; k < len; k++) begin
        r           = $urandom_range(0, 99);
        well_formed = ($urandom_range(0, 9) != 0);
        if (r < ins_pct) begin
          m  = MODE_INSERT;
          lo = (held_count + 2 > MAX_POS) ? MAX_POS : held_count + 2;
          p  = POS_W'(well_formed ? $urandom_range(1, held_count + 1)
                                  : $urandom_range(lo, MAX_POS));
        end else if (r < ins_pct + del_pct) begin
          m = MODE_DELETE;
          p = POS_W'((well_formed && held_count > 0) ? $urandom_range(1, held_count)
                                                     : $urandom_range(held_count + 1, MAX_POS));
        end else begin
          m = ($urandom_range(0, 2) == 0) ? MODE_TRAVERSE : MODE_SEARCH;
          p = POS_W'($urandom_range(1, MAX_POS));
        end
        issue(m, p, pick_value());
        sent++;
      end
      if (phase == 0) begin
        // top off the table, then push inserts into a full table
        while (held_count < TABLE_DEPTH) begin
          issue(MODE_INSERT, POS_W'($urandom_range(1, held_count + 1)), pick_value());
          sent++;
        end
        repeat (3) begin
          issue(MODE_INSERT, POS_W'($urandom_range(1, MAX_POS)), pick_value());
          sent++;
        end
        issue(MODE_TRAVERSE, 1, 0);
        sent++;
      end
      if (phase == 1 || $urandom_range(0, 1) == 1) wait_drained();
      phase++;
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
